// ===== hdl/gpp_pkg.sv =====
// ---------------------------------------------------------------------------
// gpp_pkg
// Shared types and constants of the greedy page packer: request and response
// payloads, action and status codes, sequencer states and size helpers.
// ---------------------------------------------------------------------------
package gpp_pkg;

   // request actions
   typedef enum logic [1:0] {
      ACT_VERTEX    = 2'd0,
      ACT_GROUP_END = 2'd1,
      ACT_FINISH    = 2'd2,
      ACT_NONE      = 2'd3
   } action_type;

   // response status codes
   localparam logic [1:0] STAT_PLACED   = 2'd0;
   localparam logic [1:0] STAT_OVERSIZE = 2'd1;
   localparam logic [1:0] STAT_BAD_CAP  = 2'd2;
   localparam logic [1:0] STAT_FINISHED = 2'd3;

   // csr register indexes
   localparam logic [1:0] CSR_PAGE_CAPACITY = 2'd0;
   localparam logic [1:0] CSR_HEADER_SIZE   = 2'd1;
   localparam logic [1:0] CSR_RECORD_SIZE   = 2'd2;

   localparam int CAP_W    = 21;
   localparam int HDR_W    = 11;
   localparam int REC_W    = 9;
   localparam int SIZE_W   = 28;
   localparam int CLUS_W   = 17;
   localparam int REF_W    = 21;
   localparam int VERT_W   = 17;
   localparam logic [CAP_W-1:0] CAP_MIN = 21'd1024;
   localparam logic [2:0] LAST_STEP = 3'd5;

   typedef struct packed {
      logic [1:0]  action;
      logic [11:0] vertex_id;
      logic [15:0] group_id;
      logic [7:0]  group_clusters;
      logic [15:0] group_refs;
      logic [15:0] group_tris;
      logic        is_terminal;
   } req_type;

   typedef struct packed {
      logic [15:0] out_group;
      logic [15:0] page_index;
      logic        opened_page;
      logic [1:0]  status;
   } rsp_type;

   // operands of one payload size evaluation
   typedef struct packed {
      logic [CLUS_W-1:0] clusters;
      logic [REF_W-1:0]  refs;
      logic [REF_W-1:0]  tris;
      logic [VERT_W-1:0] verts;
   } size_args_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_VCHECK,
      ST_ALONE,
      ST_JOINED,
      ST_PLACE,
      ST_WALK,
      ST_RESP
   } state_type;

   // round up to a multiple of 16
   function automatic logic [SIZE_W-1:0] align16(input logic [SIZE_W-1:0] x);
      logic [SIZE_W-1:0] s;
      s = x + SIZE_W'(15);
      return {s[SIZE_W-1:4], 4'd0};
   endfunction

endpackage

// ===== hdl/gpp_ram.sv =====
// ---------------------------------------------------------------------------
// gpp_ram
// Generic single write, single read memory with registered read data.
// ---------------------------------------------------------------------------
module gpp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ===== hdl/gpp_size_unit.sv =====
// ---------------------------------------------------------------------------
// gpp_size_unit
// Payload size evaluator: one header, product or aligned term added to an
// accumulator per cycle, six terms per evaluation.
// ---------------------------------------------------------------------------
module gpp_size_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  gpp_pkg::size_args_type      args,
   input  logic [gpp_pkg::HDR_W-1:0]   header_size,
   input  logic [gpp_pkg::REC_W-1:0]   record_size,
   output logic                        done,
   output logic [gpp_pkg::SIZE_W-1:0]  size
);
   import gpp_pkg::*;

   logic [2:0]        step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [SIZE_W-1:0] acc_ff, acc_in;
   logic [SIZE_W-1:0] term;
   logic [CLUS_W+REC_W-1:0] prod;

   // term selected by the step
   always_comb begin
      prod = (CLUS_W+REC_W)'(args.clusters) * (CLUS_W+REC_W)'(record_size);
      case (step_ff)
         3'd0:    term = SIZE_W'(header_size);
         3'd1:    term = SIZE_W'(prod);
         3'd2:    term = align16(SIZE_W'(args.refs) << 2);
         3'd3:    term = align16(SIZE_W'(args.tris) << 2);
         3'd4:    term = align16(SIZE_W'(args.verts) << 3);
         3'd5:    term = align16(SIZE_W'(args.verts) << 2);
         default: term = '0;
      endcase
   end

   // step sequencing and accumulation
   always_comb begin
      step_in = step_ff;
      busy_in = busy_ff;
      acc_in  = acc_ff;
      done_in = 1'b0;
      if (start) begin
         step_in = '0;
         busy_in = 1'b1;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in  = acc_ff + term;
         step_in = step_ff + 3'd1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign size = acc_ff;
endmodule

// ===== hdl/greedy_page_packer_core.sv =====
// ---------------------------------------------------------------------------
// greedy_page_packer_core
// Next-fit packer of ordered groups into fixed-size pages, with tag memories
// for vertex dedup and a shared serial size evaluator.
// ---------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  req_      in         valid / ready      gpp_pkg::req_type
//  rsp_      out        valid / ready      gpp_pkg::rsp_type
//  csr_      in         write enable only  index + 21-bit data
//
//  vertex request: tag memory read, then tag update
//  group end: the shared size unit sizes the group alone and, if it fits, joined
//    to the open page; then a place step and one page tag write per fresh vertex
//  finish and tag epoch wrap: tag clearing of all VERTEX_SLOTS slots, req_ready low
//  after reset: tag clearing of all VERTEX_SLOTS slots before the first request
//  a response waits in its output register; the block stalls only when a
//  second response is ready before the first is taken
// ---------------------------------------------------------------------------
module greedy_page_packer_core #(
   parameter int VERTEX_SLOTS    = 4096,
   parameter int GROUP_VERTS_MAX = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  gpp_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output gpp_pkg::rsp_type           rsp_data,
   input  logic                       csr_we,
   input  logic [1:0]                 csr_index,
   input  logic [gpp_pkg::CAP_W-1:0]  csr_wdata
);
   import gpp_pkg::*;

   localparam int VW   = $clog2(VERTEX_SLOTS);
   localparam int FI_W = $clog2(GROUP_VERTS_MAX);
   localparam int FC_W = $clog2(GROUP_VERTS_MAX + 1);
   localparam logic [VW-1:0] LAST_SLOT = VW'(VERTEX_SLOTS - 1);
   localparam logic [FC_W-1:0] FRESH_MAX = FC_W'(GROUP_VERTS_MAX);

   state_type state_ff, state_in;

   req_type   req_ff, req_in;
   rsp_type   res_ff, res_in;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff, rsp_valid_in;

   logic [CAP_W-1:0] cap_ff, cap_in;
   logic [HDR_W-1:0] hdr_ff, hdr_in;
   logic [REC_W-1:0] rec_ff, rec_in;

   logic [VW-1:0]   clear_idx_ff, clear_idx_in;
   logic            clear_page_ff, clear_page_in;
   logic            finish_ff, finish_in;
   logic [15:0]     epoch_ff, epoch_in;
   logic [FC_W-1:0] fresh_count_ff, fresh_count_in;
   logic [FC_W-1:0] new_count_ff, new_count_in;
   logic [15:0]     pc_ff, pc_in;
   logic [19:0]     pr_ff, pr_in;
   logic [19:0]     pt_ff, pt_in;
   logic [15:0]     pv_ff, pv_in;
   logic            pterm_ff, pterm_in;
   logic [15:0]     pnum_ff, pnum_in;
   logic            phas_ff, phas_in;
   logic [FC_W-1:0] walk_idx_ff, walk_idx_in;
   logic            walk_pend_ff, walk_pend_in;
   logic            start_ff, start_in;

   // memory ports
   logic            gt_we, gt_re, pt_we, pt_re, fl_we, fl_re;
   logic [VW-1:0]   gt_waddr, pt_waddr, tag_raddr;
   logic [15:0]     gt_wdata, pt_wdata, gt_rdata, pt_rdata;
   logic [FI_W-1:0] fl_waddr, fl_raddr;
   logic [11:0]     fl_wdata, fl_rdata;

   // size unit
   size_args_type   args;
   logic            size_done;
   logic [SIZE_W-1:0] size;

   logic            accept, vid_ok, bad_cap, too_big, close;
   logic [15:0]     mark, base_pc, base_pv;
   logic [19:0]     base_pr, base_pt;
   logic [FC_W-1:0] added;
   logic [16:0]     sum_c, sum_v;
   logic [20:0]     sum_r, sum_t;
   logic            has_left, slot_free;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign vid_ok  = (32'(req_data.vertex_id) < 32'(VERTEX_SLOTS));
   assign bad_cap = (cap_ff < CAP_MIN) || (cap_ff[3:0] != 4'd0);
   assign too_big = (size > SIZE_W'(cap_ff));
   assign mark    = pnum_ff + 16'd1;

   gpp_ram #(.WIDTH(16), .DEPTH(VERTEX_SLOTS)) u_group_tag (
      .clock(clock), .we(gt_we), .waddr(gt_waddr), .wdata(gt_wdata),
      .re(gt_re), .raddr(tag_raddr), .rdata(gt_rdata)
   );

   gpp_ram #(.WIDTH(16), .DEPTH(VERTEX_SLOTS)) u_page_tag (
      .clock(clock), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
      .re(pt_re), .raddr(tag_raddr), .rdata(pt_rdata)
   );

   gpp_ram #(.WIDTH(12), .DEPTH(GROUP_VERTS_MAX)) u_fresh_list (
      .clock(clock), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
      .re(fl_re), .raddr(fl_raddr), .rdata(fl_rdata)
   );

   // size operands: the group alone, or the group joined to the open page
   always_comb begin
      if (state_ff == ST_JOINED) begin
         args.clusters = CLUS_W'(pc_ff) + CLUS_W'(req_ff.group_clusters);
         args.refs     = REF_W'(pr_ff) + REF_W'(req_ff.group_refs);
         args.tris     = REF_W'(pt_ff) + REF_W'(req_ff.group_tris);
         args.verts    = VERT_W'(pv_ff) + VERT_W'(new_count_ff);
      end else begin
         args.clusters = CLUS_W'(req_ff.group_clusters);
         args.refs     = REF_W'(req_ff.group_refs);
         args.tris     = REF_W'(req_ff.group_tris);
         args.verts    = VERT_W'(fresh_count_ff);
      end
   end

   gpp_size_unit u_size (
      .clock(clock), .reset(reset), .start(start_ff), .args(args),
      .header_size(hdr_ff), .record_size(rec_ff),
      .done(size_done), .size(size)
   );

   // placement decision for the group
   always_comb begin
      close    = phas_ff && ((req_ff.is_terminal != pterm_ff) || too_big);
      base_pc  = close ? 16'd0 : pc_ff;
      base_pr  = close ? 20'd0 : pr_ff;
      base_pt  = close ? 20'd0 : pt_ff;
      base_pv  = close ? 16'd0 : pv_ff;
      added    = close ? fresh_count_ff : new_count_ff;
      has_left = close ? 1'b0 : phas_ff;
      sum_c    = 17'(base_pc) + 17'(req_ff.group_clusters);
      sum_r    = 21'(base_pr) + 21'(req_ff.group_refs);
      sum_t    = 21'(base_pt) + 21'(req_ff.group_tris);
      sum_v    = 17'(base_pv) + 17'(added);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clear_idx_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_data.action)
                  ACT_VERTEX:    state_in = vid_ok ? ST_VCHECK : ST_IDLE;
                  ACT_GROUP_END: state_in = bad_cap ? ST_RESP : ST_ALONE;
                  ACT_FINISH:    state_in = ST_RESP;
                  default:       state_in = ST_IDLE;
               endcase
            end
         end
         ST_VCHECK: state_in = ST_IDLE;
         ST_ALONE: begin
            if (size_done) begin
               state_in = too_big ? ST_RESP : ST_JOINED;
            end
         end
         ST_JOINED: begin
            if (size_done) begin
               state_in = ST_PLACE;
            end
         end
         ST_PLACE: state_in = ST_WALK;
         ST_WALK: begin
            if (walk_idx_ff >= fresh_count_ff && !walk_pend_ff) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (slot_free) begin
               if (finish_ff || epoch_ff == 16'hFFFF) begin
                  state_in = ST_CLEAR;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // datapath and memory control
   always_comb begin
      req_in         = req_ff;
      res_in         = res_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      clear_idx_in   = clear_idx_ff;
      clear_page_in  = clear_page_ff;
      finish_in      = finish_ff;
      epoch_in       = epoch_ff;
      fresh_count_in = fresh_count_ff;
      new_count_in   = new_count_ff;
      pc_in          = pc_ff;
      pr_in          = pr_ff;
      pt_in          = pt_ff;
      pv_in          = pv_ff;
      pterm_in       = pterm_ff;
      pnum_in        = pnum_ff;
      phas_in        = phas_ff;
      walk_idx_in    = walk_idx_ff;
      walk_pend_in   = 1'b0;
      start_in       = 1'b0;
      gt_we    = 1'b0;
      gt_waddr = VW'(req_ff.vertex_id);
      gt_wdata = epoch_ff;
      pt_we    = 1'b0;
      pt_waddr = VW'(fl_rdata);
      pt_wdata = mark;
      gt_re     = 1'b0;
      pt_re     = 1'b0;
      tag_raddr = VW'(req_data.vertex_id);
      fl_we    = 1'b0;
      fl_waddr = fresh_count_ff[FI_W-1:0];
      fl_wdata = req_ff.vertex_id;
      fl_re    = 1'b0;
      fl_raddr = walk_idx_ff[FI_W-1:0];

      // configuration writes
      cap_in = cap_ff;
      hdr_in = hdr_ff;
      rec_in = rec_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PAGE_CAPACITY: cap_in = csr_wdata;
            CSR_HEADER_SIZE:   hdr_in = csr_wdata[HDR_W-1:0];
            CSR_RECORD_SIZE:   rec_in = csr_wdata[REC_W-1:0];
            default:           ;
         endcase
      end

      unique case (state_ff)
         // tag sweep
         ST_CLEAR: begin
            gt_we        = 1'b1;
            gt_waddr     = clear_idx_ff;
            gt_wdata     = 16'd0;
            pt_we        = clear_page_ff;
            pt_waddr     = clear_idx_ff;
            pt_wdata     = 16'd0;
            clear_idx_in = clear_idx_ff + VW'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               req_in = req_data;
               gt_re  = 1'b1;
               pt_re  = 1'b1;
               res_in = '{out_group: req_data.group_id, page_index: 16'd0,
                          opened_page: 1'b0, status: STAT_BAD_CAP};
               finish_in = 1'b0;
               if (req_data.action == ACT_FINISH) begin
                  res_in = '{out_group: 16'd0, page_index: pnum_ff + 16'(phas_ff),
                             opened_page: 1'b0, status: STAT_FINISHED};
                  finish_in = 1'b1;
               end
               if (req_data.action == ACT_GROUP_END && !bad_cap) begin
                  start_in = 1'b1;
               end
            end
         end
         // dedup against the group and count vertices new to the page
         ST_VCHECK: begin
            if (gt_rdata != epoch_ff && fresh_count_ff < FRESH_MAX) begin
               gt_we          = 1'b1;
               fl_we          = 1'b1;
               fresh_count_in = fresh_count_ff + FC_W'(1);
               if (pt_rdata != mark) begin
                  new_count_in = new_count_ff + FC_W'(1);
               end
            end
         end
         ST_ALONE: begin
            if (size_done) begin
               res_in.status = STAT_OVERSIZE;
               start_in      = !too_big;
            end
         end
         ST_JOINED: ;
         // place the group, closing the page first if needed
         ST_PLACE: begin
            pnum_in  = close ? pnum_ff + 16'd1 : pnum_ff;
            pterm_in = has_left ? pterm_ff : req_ff.is_terminal;
            phas_in  = 1'b1;
            pc_in    = (sum_c > 17'h0FFFF) ? 16'hFFFF : sum_c[15:0];
            pr_in    = (sum_r > 21'h0FFFFF) ? 20'hFFFFF : sum_r[19:0];
            pt_in    = (sum_t > 21'h0FFFFF) ? 20'hFFFFF : sum_t[19:0];
            pv_in    = (sum_v > 17'h0FFFF) ? 16'hFFFF : sum_v[15:0];
            res_in   = '{out_group: req_ff.group_id,
                         page_index: close ? pnum_ff + 16'd1 : pnum_ff,
                         opened_page: !has_left, status: STAT_PLACED};
            walk_idx_in = '0;
         end
         // mark the group's vertices as held by the open page
         ST_WALK: begin
            if (walk_idx_ff < fresh_count_ff) begin
               fl_re        = 1'b1;
               walk_idx_in  = walk_idx_ff + FC_W'(1);
               walk_pend_in = 1'b1;
            end
            pt_we = walk_pend_ff;
         end
         // hand over the response and close out the request
         ST_RESP: begin
            if (slot_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               clear_idx_in = '0;
               fresh_count_in = '0;
               new_count_in   = '0;
               if (finish_ff) begin
                  clear_page_in = 1'b1;
                  epoch_in = 16'd1;
                  pc_in = '0;
                  pr_in = '0;
                  pt_in = '0;
                  pv_in = '0;
                  pterm_in = 1'b0;
                  pnum_in  = '0;
                  phas_in  = 1'b0;
               end else begin
                  clear_page_in = 1'b0;
                  epoch_in = (epoch_ff == 16'hFFFF) ? 16'd1 : epoch_ff + 16'd1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         rsp_valid_ff   <= 1'b0;
         cap_ff         <= 21'd65536;
         hdr_ff         <= 11'd64;
         rec_ff         <= 9'd32;
         clear_idx_ff   <= '0;
         clear_page_ff  <= 1'b1;
         finish_ff      <= 1'b0;
         epoch_ff       <= 16'd1;
         fresh_count_ff <= '0;
         new_count_ff   <= '0;
         pc_ff          <= '0;
         pr_ff          <= '0;
         pt_ff          <= '0;
         pv_ff          <= '0;
         pterm_ff       <= 1'b0;
         pnum_ff        <= '0;
         phas_ff        <= 1'b0;
         walk_idx_ff    <= '0;
         walk_pend_ff   <= 1'b0;
         start_ff       <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         cap_ff         <= cap_in;
         hdr_ff         <= hdr_in;
         rec_ff         <= rec_in;
         clear_idx_ff   <= clear_idx_in;
         clear_page_ff  <= clear_page_in;
         finish_ff      <= finish_in;
         epoch_ff       <= epoch_in;
         fresh_count_ff <= fresh_count_in;
         new_count_ff   <= new_count_in;
         pc_ff          <= pc_in;
         pr_ff          <= pr_in;
         pt_ff          <= pt_in;
         pv_ff          <= pv_in;
         pterm_ff       <= pterm_in;
         pnum_ff        <= pnum_in;
         phas_ff        <= phas_in;
         walk_idx_ff    <= walk_idx_in;
         walk_pend_ff   <= walk_pend_in;
         start_ff       <= start_in;
      end
      req_ff <= req_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end
endmodule

// ===== hdl/gpp_checker.sv =====
// ---------------------------------------------------------------------------
// gpp_checker
// Port-level checks of the page packer, bound to the top level.
// ---------------------------------------------------------------------------
module gpp_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input gpp_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input gpp_pkg::rsp_type rsp_data
);
   import gpp_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // tag clearing follows reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during tag clearing");

   // a group end or finish request keeps the block busy
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
      (req_data.action == ACT_GROUP_END || req_data.action == ACT_FINISH)
      |=> !req_ready)
      else $error("request taken while busy");

   // only a placement reports an opened page
   a_opened_placed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.opened_page |-> rsp_data.status == STAT_PLACED)
      else $error("opened page on a non-placement response");
endmodule

bind greedy_page_packer_core gpp_checker u_gpp_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .req_data(req_data),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);
